// ----- sv/lla_pkg.sv -----
`timescale 1ns / 1ps

package lla_pkg;

    // Configuration register indexes and widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int SIZE_W     = 7;
    localparam int MASK_W     = 9;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIRTH_MASK   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_MASK = 2'd3;

    // Reset values: 64 x 64 torus, rule B23/S3
    localparam logic [SIZE_W-1:0] GRID_WIDTH_RST   = 7'd64;
    localparam logic [SIZE_W-1:0] GRID_HEIGHT_RST  = 7'd64;
    localparam logic [MASK_W-1:0] BIRTH_MASK_RST   = 9'd12;
    localparam logic [MASK_W-1:0] SURVIVE_MASK_RST = 9'd8;

    // Command codes
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;

    localparam int COORD_W = 6;
    localparam int GEN_W   = 32;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               cell_in;
    } in_t;

    typedef struct packed {
        logic             cell_out;
        logic [GEN_W-1:0] generation;
        logic             bad_coord;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT_ACCESS,
        ST_WAIT_ADV,
        ST_SWEEP,
        ST_DONE
    } state_t;

endpackage

// ----- sv/lla_row_cell.sv -----
`timescale 1ns / 1ps

// One row of the grid in the rotating ring; loads its neighbor's row every cycle
module lla_row_cell #(
    parameter int ROW_W = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [ROW_W-1:0] row_d,
    output logic [ROW_W-1:0] row_q
);

    logic [ROW_W-1:0] row_reg;

    // all cells dead after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else begin
            row_reg <= row_d;
        end
    end

    assign row_q = row_reg;

endmodule

// ----- sv/lla_row_update.sv -----
`timescale 1ns / 1ps

// Next generation of one row from the rows above, at and below it
module lla_row_update #(
    parameter int MAX_WIDTH = 64
) (
    input  logic [MAX_WIDTH-1:0]          up_row,
    input  logic [MAX_WIDTH-1:0]          cur_row,
    input  logic [MAX_WIDTH-1:0]          dn_row,
    input  logic [lla_pkg::SIZE_W-1:0]    used_w,
    input  logic [lla_pkg::MASK_W-1:0]    birth_mask,
    input  logic [lla_pkg::MASK_W-1:0]    survive_mask,
    output logic [MAX_WIDTH-1:0]          new_row
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [CW-1:0] last_col;
    logic          up_last;
    logic          cur_last;
    logic          dn_last;

    // column w-1 is the left neighbor of column 0
    assign last_col = CW'(used_w - 7'd1);
    assign up_last  = up_row[last_col];
    assign cur_last = cur_row[last_col];
    assign dn_last  = dn_row[last_col];

    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_col
        logic       up_l, cur_l, dn_l;
        logic       up_r, cur_r, dn_r;
        logic       in_use;
        logic [3:0] count;
        logic [8:0] rule;

        assign in_use = 32'(c) < 32'(used_w);

        // left neighbors
        if (c == 0) begin : g_left_wrap
            assign up_l  = up_last;
            assign cur_l = cur_last;
            assign dn_l  = dn_last;
        end else begin : g_left
            assign up_l  = up_row[c-1];
            assign cur_l = cur_row[c-1];
            assign dn_l  = dn_row[c-1];
        end

        // right neighbors: column 0 past the last column in use
        if (c == MAX_WIDTH - 1) begin : g_right_wrap
            assign up_r  = up_row[0];
            assign cur_r = cur_row[0];
            assign dn_r  = dn_row[0];
        end else begin : g_right
            logic wrap;
            assign wrap  = 32'(c + 1) >= 32'(used_w);
            assign up_r  = wrap ? up_row[0]  : up_row[c+1];
            assign cur_r = wrap ? cur_row[0] : cur_row[c+1];
            assign dn_r  = wrap ? dn_row[0]  : dn_row[c+1];
        end

        assign count = 4'(up_l) + 4'(up_row[c]) + 4'(up_r)
                     + 4'(cur_l) + 4'(cur_r)
                     + 4'(dn_l) + 4'(dn_row[c]) + 4'(dn_r);

        assign rule       = cur_row[c] ? survive_mask : birth_mask;
        assign new_row[c] = in_use ? rule[count] : cur_row[c];
    end

endmodule

// ----- sv/life_like_automaton_torus.sv -----
`timescale 1ns / 1ps
// Write/read: the result beat waits for the addressed row to reach the head of the
// rotating row ring. Advance: waits for row 0 to reach the head, then sweeps the rows
// (one row per cycle) and finishes.
// One item at a time; a finished beat waits in the output register while the next is taken.
// Synchronous active-low reset clears all cells, the generation count and the output
// valid, and loads the configuration defaults; no clearing pass is needed.
module life_like_automaton_torus #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  lla_pkg::in_t                      s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output lla_pkg::out_t                     m_data,
    input  logic                              cfg_wen,
    input  logic [lla_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lla_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    // Configuration registers
    logic [lla_pkg::SIZE_W-1:0] grid_width_reg, grid_height_reg;
    logic [lla_pkg::MASK_W-1:0] birth_mask_reg, survive_mask_reg;

    // Control and item registers
    lla_pkg::state_t              state_reg, state_next;
    logic [PW-1:0]                ptr_reg, ptr_next;
    logic [1:0]                   cmd_reg, cmd_next;
    logic [lla_pkg::COORD_W-1:0]  row_reg, row_next;
    logic [CW-1:0]                col_reg, col_next;
    logic                         val_reg, val_next;
    logic                         cell_out_reg, cell_out_next;
    logic                         bad_reg, bad_next;
    logic [lla_pkg::GEN_W-1:0]    gen_reg, gen_next;
    logic                         m_valid_reg, m_valid_next;
    lla_pkg::out_t                m_data_reg, m_data_next;

    // Old rows kept for the wrap-around neighbors during a sweep
    logic [MAX_WIDTH-1:0] first_old_reg, first_old_next;
    logic [MAX_WIDTH-1:0] second_old_reg, second_old_next;
    logic [MAX_WIDTH-1:0] last_old_reg, last_old_next;
    logic [MAX_WIDTH-1:0] prev_old_reg, prev_old_next;

    // Ring of rows; position 0 is the head and holds row ptr_reg
    logic [MAX_WIDTH-1:0] row_q [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] row_d [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] head, head_next;
    logic [MAX_WIDTH-1:0] up_sel, dn_sel, upd_row;

    logic [lla_pkg::SIZE_W-1:0] used_w;
    logic [HW-1:0]              used_h, h_last;
    logic                       at_row, ptr_in_h, ptr_at_last, in_bad;

    // Size in use, clamped to 1..MAX
    always_comb begin
        if (grid_width_reg == '0) begin
            used_w = 7'd1;
        end else if (32'(grid_width_reg) > MAX_WIDTH) begin
            used_w = 7'(MAX_WIDTH);
        end else begin
            used_w = grid_width_reg;
        end
        if (grid_height_reg == '0) begin
            used_h = HW'(1);
        end else if (32'(grid_height_reg) > MAX_HEIGHT) begin
            used_h = HW'(MAX_HEIGHT);
        end else begin
            used_h = HW'(grid_height_reg);
        end
    end

    assign h_last      = used_h - HW'(1);
    assign head        = row_q[0];
    assign at_row      = 32'(ptr_reg) == 32'(row_reg);
    assign ptr_in_h    = 32'(ptr_reg) < 32'(used_h);
    assign ptr_at_last = 32'(ptr_reg) == 32'(h_last);
    assign in_bad      = (32'(s_data.row) >= 32'(used_h)) || (32'(s_data.col) >= 32'(used_w));

    // Row ring
    for (genvar i = 0; i < MAX_HEIGHT; i++) begin : g_ring
        if (i == MAX_HEIGHT - 1) begin : g_tail
            assign row_d[i] = head_next;
        end else begin : g_link
            assign row_d[i] = row_q[i+1];
        end
        lla_row_cell #(
            .ROW_W (MAX_WIDTH)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .row_d   (row_d[i]),
            .row_q   (row_q[i])
        );
    end

    lla_row_update #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_update (
        .up_row       (up_sel),
        .cur_row      (head),
        .dn_row       (dn_sel),
        .used_w       (used_w),
        .birth_mask   (birth_mask_reg),
        .survive_mask (survive_mask_reg),
        .new_row      (upd_row)
    );

    // Head row: rule update during the sweep, cell write on access
    always_comb begin
        head_next = head;
        up_sel    = prev_old_reg;
        dn_sel    = ptr_at_last ? first_old_reg : row_q[1];
        if (state_reg == lla_pkg::ST_SWEEP) begin
            if (ptr_reg == '0) begin
                // row 0 is done last, once old rows 1 and h-1 are known
                up_sel    = last_old_reg;
                dn_sel    = (used_h == HW'(1)) ? head : second_old_reg;
                head_next = upd_row;
            end else if (ptr_in_h) begin
                head_next = upd_row;
            end
        end else if (state_reg == lla_pkg::ST_WAIT_ACCESS && at_row
                     && cmd_reg == lla_pkg::CMD_WRITE) begin
            head_next[col_reg] = val_reg;
        end
    end

    assign ptr_next = (ptr_reg == PW'(MAX_HEIGHT - 1)) ? '0 : ptr_reg + PW'(1);

    // Next state and outputs
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        val_next        = val_reg;
        cell_out_next   = cell_out_reg;
        bad_next        = bad_reg;
        gen_next        = gen_reg;
        first_old_next  = first_old_reg;
        second_old_next = second_old_reg;
        last_old_next   = last_old_reg;
        prev_old_next   = prev_old_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg;
        s_ready         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            lla_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next      = s_data.cmd;
                    row_next      = s_data.row;
                    col_next      = s_data.col[CW-1:0];
                    val_next      = s_data.cell_in;
                    cell_out_next = 1'b0;
                    bad_next      = 1'b0;
                    if (s_data.cmd == lla_pkg::CMD_WRITE || s_data.cmd == lla_pkg::CMD_READ) begin
                        if (in_bad) begin
                            bad_next   = 1'b1;
                            state_next = lla_pkg::ST_DONE;
                        end else begin
                            state_next = lla_pkg::ST_WAIT_ACCESS;
                        end
                    end else if (s_data.cmd == lla_pkg::CMD_ADVANCE) begin
                        state_next = lla_pkg::ST_WAIT_ADV;
                    end else begin
                        state_next = lla_pkg::ST_DONE;
                    end
                end
            end
            lla_pkg::ST_WAIT_ACCESS: begin
                if (at_row) begin
                    if (cmd_reg == lla_pkg::CMD_READ) begin
                        cell_out_next = head[col_reg];
                    end
                    state_next = lla_pkg::ST_DONE;
                end
            end
            lla_pkg::ST_WAIT_ADV: begin
                // old row 0 passes the head; keep it for the later wraps
                if (ptr_reg == '0) begin
                    first_old_next = head;
                    prev_old_next  = head;
                    if (used_h == HW'(1)) begin
                        last_old_next = head;
                    end
                    state_next = lla_pkg::ST_SWEEP;
                end
            end
            lla_pkg::ST_SWEEP: begin
                prev_old_next = head;
                if (ptr_reg == '0) begin
                    gen_next   = gen_reg + 32'd1;
                    state_next = lla_pkg::ST_DONE;
                end else if (ptr_in_h) begin
                    if (ptr_reg == PW'(1)) begin
                        second_old_next = head;
                    end
                    if (ptr_at_last) begin
                        last_old_next = head;
                    end
                end
            end
            lla_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.cell_out   = cell_out_reg;
                    m_data_next.generation = gen_reg;
                    m_data_next.bad_coord  = bad_reg;
                    state_next             = lla_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lla_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lla_pkg::ST_IDLE;
            ptr_reg     <= '0;
            gen_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            gen_reg     <= gen_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        val_reg        <= val_next;
        cell_out_reg   <= cell_out_next;
        bad_reg        <= bad_next;
        first_old_reg  <= first_old_next;
        second_old_reg <= second_old_next;
        last_old_reg   <= last_old_next;
        prev_old_reg   <= prev_old_next;
        m_data_reg     <= m_data_next;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg   <= lla_pkg::GRID_WIDTH_RST;
            grid_height_reg  <= lla_pkg::GRID_HEIGHT_RST;
            birth_mask_reg   <= lla_pkg::BIRTH_MASK_RST;
            survive_mask_reg <= lla_pkg::SURVIVE_MASK_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                lla_pkg::REG_GRID_WIDTH:   grid_width_reg   <= cfg_wdata[lla_pkg::SIZE_W-1:0];
                lla_pkg::REG_GRID_HEIGHT:  grid_height_reg  <= cfg_wdata[lla_pkg::SIZE_W-1:0];
                lla_pkg::REG_BIRTH_MASK:   birth_mask_reg   <= cfg_wdata;
                lla_pkg::REG_SURVIVE_MASK: survive_mask_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- dv/torus_grid_checker.sv -----
`timescale 1ns / 1ps

module torus_grid_checker #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  lla_pkg::in_t                   s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  lla_pkg::out_t                  m_data,
    input  logic                           cfg_wen,
    input  logic [lla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lla_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int unsigned                    mismatches,
    output int unsigned                    in_flight,
    output int unsigned                    results_seen
);

    localparam int GW = lla_pkg::GEN_W;

    // Shadow of the grid, the generation count and the four registers
    logic [63:0]                 cells [MAX_HEIGHT];
    logic [lla_pkg::GEN_W-1:0]   gen_count;
    logic [lla_pkg::SIZE_W-1:0]  width_reg;
    logic [lla_pkg::SIZE_W-1:0]  height_reg;
    logic [lla_pkg::MASK_W-1:0]  birth_rule;
    logic [lla_pkg::MASK_W-1:0]  survive_rule;

    lla_pkg::out_t awaited_results [$];

    // Size registers: zero acts as one, anything past the maximum as the maximum
    function automatic int unsigned size_in_use(input logic [lla_pkg::SIZE_W-1:0] v,
                                                input int unsigned limit);
        if (v == 0) return 1;
        if (32'(v) > limit) return limit;
        return 32'(v);
    endfunction

    // Eight wrapped neighbors; on a tiny torus repeated positions count each time
    function automatic int unsigned live_around(input int unsigned r, input int unsigned c,
                                                input int unsigned w, input int unsigned h);
        int unsigned rows [3];
        int unsigned cols [3];
        int unsigned n;
        rows[0] = (r == 0) ? h - 1 : r - 1;
        rows[1] = r;
        rows[2] = (r + 1 >= h) ? 0 : r + 1;
        cols[0] = (c == 0) ? w - 1 : c - 1;
        cols[1] = c;
        cols[2] = (c + 1 >= w) ? 0 : c + 1;
        n = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (i != 1 || j != 1)
                    n += 32'(cells[rows[i]][cols[j]]);
        return n;
    endfunction

    // One generation over the cells in use, all from the old grid
    function automatic void step_generation();
        logic [63:0]                next_cells [MAX_HEIGHT];
        logic [lla_pkg::MASK_W-1:0] rule;
        int unsigned                w;
        int unsigned                h;
        w = size_in_use(width_reg, MAX_WIDTH);
        h = size_in_use(height_reg, MAX_HEIGHT);
        next_cells = cells;
        for (int unsigned r = 0; r < h; r++) begin
            for (int unsigned c = 0; c < w; c++) begin
                rule = cells[r][c] ? survive_rule : birth_rule;
                next_cells[r][c] = rule[live_around(r, c, w, h)];
            end
        end
        cells = next_cells;
        gen_count = gen_count + 1;
    endfunction

    // Applies one beat to the shadow state and returns the result it must produce
    function automatic lla_pkg::out_t predict_result(input lla_pkg::in_t beat);
        lla_pkg::out_t res;
        int unsigned   w;
        int unsigned   h;
        res = '0;
        w = size_in_use(width_reg, MAX_WIDTH);
        h = size_in_use(height_reg, MAX_HEIGHT);
        case (beat.cmd)
            lla_pkg::CMD_WRITE, lla_pkg::CMD_READ: begin
                if (32'(beat.row) >= h || 32'(beat.col) >= w)
                    res.bad_coord = 1'b1;
                else if (beat.cmd == lla_pkg::CMD_WRITE)
                    cells[beat.row][beat.col] = beat.cell_in;
                else
                    res.cell_out = cells[beat.row][beat.col];
            end
            lla_pkg::CMD_ADVANCE: step_generation();
            default: ;
        endcase
        res.generation = gen_count;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [lla_pkg::GEN_W-1:0] got,
                                   input logic [lla_pkg::GEN_W-1:0] want);
        mismatches++;
        $display("[%0t] result %0d: %s is %0d, expected %0d",
                 $time, results_seen, what, got, want);
    endtask

    // Track config writes and both channels; results are compared in order
    always @(posedge aclk) begin
        lla_pkg::out_t want;
        if (!aresetn) begin
            foreach (cells[r]) cells[r] = '0;
            gen_count    = '0;
            width_reg    = lla_pkg::GRID_WIDTH_RST;
            height_reg   = lla_pkg::GRID_HEIGHT_RST;
            birth_rule   = lla_pkg::BIRTH_MASK_RST;
            survive_rule = lla_pkg::SURVIVE_MASK_RST;
            awaited_results.delete();
            mismatches   = 0;
            results_seen = 0;
            in_flight <= 0;
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    lla_pkg::REG_GRID_WIDTH:   width_reg    = cfg_wdata[lla_pkg::SIZE_W-1:0];
                    lla_pkg::REG_GRID_HEIGHT:  height_reg   = cfg_wdata[lla_pkg::SIZE_W-1:0];
                    lla_pkg::REG_BIRTH_MASK:   birth_rule   = cfg_wdata[lla_pkg::MASK_W-1:0];
                    lla_pkg::REG_SURVIVE_MASK: survive_rule = cfg_wdata[lla_pkg::MASK_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    report_mismatch("beat with nothing awaited, generation",
                                    m_data.generation, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_data.cell_out !== want.cell_out)
                        report_mismatch("cell_out", GW'(m_data.cell_out), GW'(want.cell_out));
                    if (m_data.generation !== want.generation)
                        report_mismatch("generation", m_data.generation, want.generation);
                    if (m_data.bad_coord !== want.bad_coord)
                        report_mismatch("bad_coord", GW'(m_data.bad_coord),
                                        GW'(want.bad_coord));
                end
            end
            if (s_valid && s_ready)
                awaited_results = {awaited_results, predict_result(s_data)};
            in_flight <= awaited_results.size();
        end
    end

endmodule

// ----- dv/tb_life_like_automaton_torus.sv -----
`timescale 1ns / 1ps

module tb_life_like_automaton_torus;

    localparam int unsigned GRID_MAX    = 64;
    localparam int unsigned IDLE_PCT    = 23;
    localparam int unsigned RAND_PHASES = 13;
    localparam int unsigned PHASE_BEATS = 110;
    localparam int unsigned TAIL_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          COORD_BITS  = lla_pkg::COORD_W;
    localparam int          DW          = lla_pkg::CFG_DATA_W;
    localparam int          SW          = lla_pkg::SIZE_W;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    lla_pkg::in_t                   s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    lla_pkg::out_t                  m_data;
    logic                           cfg_wen   = 1'b0;
    logic [lla_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lla_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int unsigned mismatches;
    int unsigned in_flight;
    int unsigned results_seen;

    // Stimulus bookkeeping
    bit          idle_on   = 1'b1;
    int unsigned cur_w     = GRID_MAX;
    int unsigned cur_h     = GRID_MAX;
    int unsigned beats_out = 0;
    int unsigned steps_out = 0;
    int unsigned configs   = 1;
    int unsigned cycles    = 0;

    always #4 aclk = ~aclk;

    life_like_automaton_torus dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    torus_grid_checker grid_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .in_flight    (in_flight),
        .results_seen (results_seen)
    );

    // Result side back-pressure
    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited", cycles, in_flight);
            $display("FAIL");
            $finish;
        end
    end

    function automatic lla_pkg::in_t make_beat(input logic [1:0] cmd, input int unsigned r,
                                               input int unsigned c, input logic v);
        lla_pkg::in_t b;
        b.cmd     = cmd;
        b.row     = r[COORD_BITS-1:0];
        b.col     = c[COORD_BITS-1:0];
        b.cell_in = v;
        return b;
    endfunction

    // Mostly in-range writes, reads and steps; a few unused commands and stray coordinates
    function automatic lla_pkg::in_t random_beat();
        int unsigned  roll;
        lla_pkg::in_t b;
        roll = $urandom_range(99);
        b = make_beat(lla_pkg::CMD_WRITE, $urandom_range(cur_h - 1), $urandom_range(cur_w - 1),
                      $urandom_range(99) < 60);
        if (roll >= 42 && roll < 70) begin
            b.cmd = lla_pkg::CMD_READ;
        end else if (roll >= 70 && roll < 88) begin
            b.cmd = lla_pkg::CMD_ADVANCE;
            b.row = COORD_BITS'($urandom_range(63));
            b.col = COORD_BITS'($urandom_range(63));
        end else if (roll >= 88 && roll < 92) begin
            b.cmd = CMD_UNUSED;
            b.row = COORD_BITS'($urandom_range(63));
            b.col = COORD_BITS'($urandom_range(63));
        end else if (roll >= 92) begin
            b.cmd = $urandom_range(1) ? lla_pkg::CMD_READ : lla_pkg::CMD_WRITE;
            b.row = COORD_BITS'($urandom_range(63));
            b.col = COORD_BITS'($urandom_range(63));
        end
        return b;
    endfunction

    // Holds valid across back-to-back beats; returns at the accepting edge
    task automatic send_beat(input lla_pkg::in_t beat);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        beats_out++;
        if (beat.cmd == lla_pkg::CMD_ADVANCE)
            steps_out++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0) @(posedge aclk);
    endtask

    // Writes all four registers; only called with nothing in flight
    task automatic set_config(input logic [DW-1:0] w, input logic [DW-1:0] h,
                              input logic [DW-1:0] birth,
                              input logic [DW-1:0] survive);
        logic [lla_pkg::CFG_IDX_W-1:0] idx  [4];
        logic [DW-1:0]                 vals [4];
        idx  = '{lla_pkg::REG_GRID_WIDTH, lla_pkg::REG_GRID_HEIGHT,
                 lla_pkg::REG_BIRTH_MASK, lla_pkg::REG_SURVIVE_MASK};
        vals = '{w, h, birth, survive};
        for (int i = 0; i < 4; i++) begin
            cfg_wen   <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wen <= 1'b0;
        cur_w = (w[SW-1:0] == 0) ? 1 : (32'(w[SW-1:0]) > GRID_MAX) ? GRID_MAX : 32'(w[SW-1:0]);
        cur_h = (h[SW-1:0] == 0) ? 1 : (32'(h[SW-1:0]) > GRID_MAX) ? GRID_MAX : 32'(h[SW-1:0]);
        configs++;
    endtask

    initial begin
        logic [DW-1:0] w, h, birth, survive;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset rule on the full torus: a blinker across both wraps
        send_beat(make_beat(lla_pkg::CMD_READ, 63, 63, 1'b0));
        send_beat(make_beat(lla_pkg::CMD_WRITE, 0, 63, 1'b1));
        send_beat(make_beat(lla_pkg::CMD_WRITE, 0, 0, 1'b1));
        send_beat(make_beat(lla_pkg::CMD_WRITE, 0, 1, 1'b1));
        send_beat(make_beat(lla_pkg::CMD_ADVANCE, 63, 63, 1'b1));
        send_beat(make_beat(lla_pkg::CMD_READ, 63, 0, 1'b0));
        send_beat(make_beat(lla_pkg::CMD_READ, 1, 0, 1'b0));
        send_beat(make_beat(CMD_UNUSED, 63, 63, 1'b1));
        send_beat(make_beat(lla_pkg::CMD_ADVANCE, 0, 0, 1'b0));
        drain();

        // Size zero acts as a 1x1 torus: the cell is its own eight neighbors
        set_config('0, '0, 9'h1FF, '0);
        send_beat(make_beat(lla_pkg::CMD_WRITE, 0, 1, 1'b1));
        send_beat(make_beat(lla_pkg::CMD_READ, 1, 0, 1'b0));
        send_beat(make_beat(lla_pkg::CMD_WRITE, 0, 0, 1'b1));
        send_beat(make_beat(lla_pkg::CMD_ADVANCE, 0, 0, 1'b0));
        send_beat(make_beat(lla_pkg::CMD_READ, 0, 0, 1'b0));
        send_beat(make_beat(lla_pkg::CMD_ADVANCE, 0, 0, 1'b0));
        send_beat(make_beat(lla_pkg::CMD_READ, 63, 63, 1'b0));
        drain();

        // Oversize registers clamp to 64x64; nothing born, everything survives
        set_config(9'd127, 9'd127, '0, 9'h1FF);
        send_beat(make_beat(lla_pkg::CMD_READ, 0, 0, 1'b0));
        send_beat(make_beat(lla_pkg::CMD_ADVANCE, 0, 0, 1'b0));
        send_beat(make_beat(lla_pkg::CMD_WRITE, 63, 63, 1'b0));
        send_beat(make_beat(lla_pkg::CMD_READ, 0, 63, 1'b0));
        drain();

        // 2x2 torus: each side neighbor is seen twice, the diagonal one four times
        set_config(9'd2, 9'd2, 9'h010, 9'h100);
        send_beat(make_beat(lla_pkg::CMD_WRITE, 0, 0, 1'b1));
        send_beat(make_beat(lla_pkg::CMD_WRITE, 1, 1, 1'b1));
        send_beat(make_beat(lla_pkg::CMD_ADVANCE, 0, 0, 1'b0));
        send_beat(make_beat(lla_pkg::CMD_READ, 1, 0, 1'b0));
        send_beat(make_beat(lla_pkg::CMD_READ, 2, 0, 1'b0));
        drain();

        // Random phases, each under its own size and rule
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            birth   = DW'($urandom_range(511));
            survive = DW'($urandom_range(511));
            case (ph)
                0: begin
                    w = DW'(lla_pkg::GRID_WIDTH_RST);
                    h = DW'(lla_pkg::GRID_HEIGHT_RST);
                    birth = DW'(lla_pkg::BIRTH_MASK_RST);
                    survive = DW'(lla_pkg::SURVIVE_MASK_RST);
                end
                1: begin w = 9'd1; h = 9'd1; end
                2: begin w = 9'd2; h = 9'd2; end
                3: begin w = 9'd127; h = '0; end
                4: begin w = '0; h = 9'd127; end
                5: begin w = 9'd3; h = 9'd3; birth = '0; survive = 9'h1FF; end
                default: begin
                    if ($urandom_range(3) == 0) begin
                        w = DW'($urandom_range(127));
                        h = DW'($urandom_range(127));
                    end else begin
                        w = DW'($urandom_range(16, 3));
                        h = DW'($urandom_range(16, 3));
                    end
                    // classic B3/S23 now and then
                    if ($urandom_range(3) == 0) begin
                        birth = 9'h008;
                        survive = 9'h00C;
                    end
                end
            endcase
            set_config(w, h, birth, survive);
            // two phases run without any idling on either side
            idle_on = !(ph == 7 || ph == 8);
            for (int i = 0; i < PHASE_BEATS; i++)
                send_beat(random_beat());
            drain();
        end
        idle_on = 1'b1;

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d beats including %0d generation steps across %0d grid setups",
                 beats_out, steps_out, configs);
        $display("Checked %0d results; sizes from 1x1 to 64x64 incl. clamped registers",
                 results_seen);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end

endmodule
